[src/hrpd_pkg.sv]
package hrpd_pkg;

	localparam int CHAN_W = 8;
	localparam int DUTY_W = 10;

	typedef logic [CHAN_W-1:0] chan_t;
	typedef logic [DUTY_W-1:0] duty_t;

	// func selector carried in tuser
	localparam logic FUNC_LEVEL = 1'b0;
	localparam logic FUNC_COLOR = 1'b1;

	// full-scale input code for level, hue and saturation
	localparam int FULL_SCALE = 254;

	// 2^24 / 254 rounded up: exact floor division for dividends below 68200
	localparam int REC254_SHIFT = 24;
	localparam int REC254 = 66053;

	// number of pipeline registers per block
	localparam int HSV_STAGES = 7;
	localparam int DUTY_STAGES = 2;
	localparam int PIPE_STAGES = HSV_STAGES + DUTY_STAGES;

endpackage

[src/hsv_to_rgb_pwm_duty_top.sv]
// channel  dir  tdata (low bit up)                          tuser
// s_*      in   level[7:0] hue[15:8] saturation[23:16]      func
// m_*      out  red_duty[9:0] green_duty[19:10]
//               blue_duty[29:20] zero[31:30]                -
//
// One beat per cycle sustained while m_tready stays high.
// The pipe has nine register stages: seven for the HSV math, two for duty scaling.
// Reset clears only the stage valid bits.
// Each stage loads when it is empty or the next one moves, so bubbles close up and
// s_tready stays high while the output holds a waiting beat and earlier stages have room.
module hsv_to_rgb_pwm_duty_top
	import hrpd_pkg::*;
#(
	parameter int PWM_PERIOD = 1000
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // level, hue, saturation
	input  logic        s_tuser,   // func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // red_duty, green_duty, blue_duty, zero pad
);

	logic [PIPE_STAGES-1:0] stage_vld_q;
	logic [PIPE_STAGES:0]   adv;
	chan_t                  red, green, blue;
	duty_t                  red_duty, green_duty, blue_duty;

	always_comb begin
		adv[PIPE_STAGES] = m_tready;
		for (int k = PIPE_STAGES - 1; k >= 0; k--) begin
			adv[k] = !stage_vld_q[k] || adv[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
		end else begin
			for (int k = 0; k < PIPE_STAGES; k++) begin
				if (adv[k]) begin
					stage_vld_q[k] <= (k == 0) ? s_tvalid : stage_vld_q[k-1];
				end
			end
		end
	end

	hrpd_hsv u_hsv (
		.clk        (clk),
		.en         (adv[HSV_STAGES-1:0]),
		.func       (s_tuser),
		.level      (s_tdata[7:0]),
		.hue        (s_tdata[15:8]),
		.saturation (s_tdata[23:16]),
		.red        (red),
		.green      (green),
		.blue       (blue)
	);

	hrpd_duty #(.PWM_PERIOD(PWM_PERIOD)) u_duty_r (
		.clk  (clk),
		.en   (adv[PIPE_STAGES-1:HSV_STAGES]),
		.x    (red),
		.duty (red_duty)
	);

	hrpd_duty #(.PWM_PERIOD(PWM_PERIOD)) u_duty_g (
		.clk  (clk),
		.en   (adv[PIPE_STAGES-1:HSV_STAGES]),
		.x    (green),
		.duty (green_duty)
	);

	hrpd_duty #(.PWM_PERIOD(PWM_PERIOD)) u_duty_b (
		.clk  (clk),
		.en   (adv[PIPE_STAGES-1:HSV_STAGES]),
		.x    (blue),
		.duty (blue_duty)
	);

	assign s_tready = adv[0];
	assign m_tvalid = stage_vld_q[PIPE_STAGES-1];
	assign m_tdata  = {2'b00, blue_duty, green_duty, red_duty};

	// a free output means the whole pipe can move
	assert property (@(posedge clk) disable iff (!arst_n)
		(!m_tvalid || m_tready) |-> s_tready)
		else $error("input stalled while output side is free");

	// beats in flight change only by what is taken in and handed out
	assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> ($countones(stage_vld_q) == $past($countones(stage_vld_q))
			+ $past(int'(s_tvalid && s_tready)) - $past(int'(m_tvalid && m_tready))))
		else $error("beat lost or duplicated in pipeline");

endmodule

[src/hrpd_hsv.sv]
module hrpd_hsv
	import hrpd_pkg::*;
(
	input  logic                  clk,
	input  logic [HSV_STAGES-1:0] en,
	input  logic                  func,
	input  chan_t                 level,
	input  chan_t                 hue,
	input  chan_t                 saturation,
	output chan_t                 red,
	output chan_t                 green,
	output chan_t                 blue
);

	localparam int DEG_W = 9;
	localparam int PCT_W = 7;
	localparam int SEC_W = 3;
	localparam int REM_W = 6;

	localparam int LEVEL_FLOOR = 5;
	localparam int PCT_FULL = 100;
	localparam int SEC_SPAN = 60;
	// 360/254 and 100/254 reduced by two, then divided by 127 through a reciprocal
	localparam int HUE_MUL = 360 / 2;
	localparam int SAT_MUL = 100 / 2;
	localparam int REC127_SHIFT = 23;
	localparam int REC127 = 66053;
	localparam int REC100_SHIFT = 19;
	localparam int REC100 = 5243;
	localparam int REC60_SHIFT = 20;
	localparam int REC60 = 17477;

	localparam logic [SEC_W-1:0] SEC_RED_UP   = 3'd0;
	localparam logic [SEC_W-1:0] SEC_GRN_DN   = 3'd1;
	localparam logic [SEC_W-1:0] SEC_GRN_UP   = 3'd2;
	localparam logic [SEC_W-1:0] SEC_BLU_DN   = 3'd3;
	localparam logic [SEC_W-1:0] SEC_BLU_UP   = 3'd4;
	localparam logic [SEC_W-1:0] SEC_MAG      = 3'd5;
	localparam logic [SEC_W-1:0] SEC_OVER     = 3'd6;

	// stage 1: level floor, hue and saturation prescale
	logic              func_s1;
	chan_t             vmax_s1;
	logic [15:0]       hv_s1;
	logic [13:0]       sv_s1;
	chan_t             lvl_r;

	always_comb begin
		lvl_r = level;
		if (level >= CHAN_W'(1) && level <= CHAN_W'(LEVEL_FLOOR)) begin
			lvl_r = CHAN_W'(LEVEL_FLOOR);
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			func_s1 <= func;
			vmax_s1 <= lvl_r;
			hv_s1   <= 16'(hue) * 16'(HUE_MUL);
			sv_s1   <= 14'(saturation) * 14'(SAT_MUL);
		end
	end

	// stage 2: divide by 127
	logic              func_s2;
	chan_t             vmax_s2;
	logic [DEG_W-1:0]  deg_s2;
	logic [PCT_W-1:0]  pct_s2;
	logic [32:0]       hp;
	logic [32:0]       sp;

	assign hp = 33'(hv_s1) * 33'(REC127);
	assign sp = 33'(sv_s1) * 33'(REC127);

	always_ff @(posedge clk) begin
		if (en[1]) begin
			func_s2 <= func_s1;
			vmax_s2 <= vmax_s1;
			deg_s2  <= hp[REC127_SHIFT +: DEG_W];
			pct_s2  <= sp[REC127_SHIFT +: PCT_W];
		end
	end

	// stage 3: sector split, vmin numerator
	logic              func_s3;
	chan_t             vmax_s3;
	logic [SEC_W-1:0]  sec_s3;
	logic [REM_W-1:0]  rem_s3;
	logic [14:0]       num_s3;
	logic [SEC_W-1:0]  sec_c;
	logic [DEG_W-1:0]  base_c;
	logic [PCT_W-1:0]  pct_c;
	logic [DEG_W-1:0]  rem_c;

	always_comb begin
		// hue codes 254 and 255 land at or past 360 and share their own sector
		if (deg_s2 >= DEG_W'(6 * SEC_SPAN)) begin
			sec_c = SEC_OVER;   base_c = DEG_W'(6 * SEC_SPAN);
		end else if (deg_s2 >= DEG_W'(5 * SEC_SPAN)) begin
			sec_c = SEC_MAG;    base_c = DEG_W'(5 * SEC_SPAN);
		end else if (deg_s2 >= DEG_W'(4 * SEC_SPAN)) begin
			sec_c = SEC_BLU_UP; base_c = DEG_W'(4 * SEC_SPAN);
		end else if (deg_s2 >= DEG_W'(3 * SEC_SPAN)) begin
			sec_c = SEC_BLU_DN; base_c = DEG_W'(3 * SEC_SPAN);
		end else if (deg_s2 >= DEG_W'(2 * SEC_SPAN)) begin
			sec_c = SEC_GRN_UP; base_c = DEG_W'(2 * SEC_SPAN);
		end else if (deg_s2 >= DEG_W'(SEC_SPAN)) begin
			sec_c = SEC_GRN_DN; base_c = DEG_W'(SEC_SPAN);
		end else begin
			sec_c = SEC_RED_UP; base_c = '0;
		end
		rem_c = deg_s2 - base_c;
		pct_c = (pct_s2 > PCT_W'(PCT_FULL)) ? PCT_W'(PCT_FULL) : pct_s2;
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			func_s3 <= func_s2;
			vmax_s3 <= vmax_s2;
			sec_s3  <= sec_c;
			rem_s3  <= rem_c[REM_W-1:0];
			num_s3  <= 15'(vmax_s2) * 15'(PCT_W'(PCT_FULL) - pct_c);
		end
	end

	// stage 4: vmin = num / 100
	logic              func_s4;
	chan_t             vmax_s4;
	chan_t             vmin_s4;
	logic [SEC_W-1:0]  sec_s4;
	logic [REM_W-1:0]  rem_s4;
	logic [27:0]       np;

	assign np = 28'(num_s3) * 28'(REC100);

	always_ff @(posedge clk) begin
		if (en[3]) begin
			func_s4 <= func_s3;
			vmax_s4 <= vmax_s3;
			vmin_s4 <= np[REC100_SHIFT +: CHAN_W];
			sec_s4  <= sec_s3;
			rem_s4  <= rem_s3;
		end
	end

	// stage 5: span times offset within sector
	logic              func_s5;
	chan_t             vmax_s5;
	chan_t             vmin_s5;
	logic [SEC_W-1:0]  sec_s5;
	logic [13:0]       prod_s5;

	always_ff @(posedge clk) begin
		if (en[4]) begin
			func_s5 <= func_s4;
			vmax_s5 <= vmax_s4;
			vmin_s5 <= vmin_s4;
			sec_s5  <= sec_s4;
			prod_s5 <= 14'(vmax_s4 - vmin_s4) * 14'(rem_s4);
		end
	end

	// stage 6: adj = prod / 60
	logic              func_s6;
	chan_t             vmax_s6;
	chan_t             vmin_s6;
	logic [SEC_W-1:0]  sec_s6;
	chan_t             adj_s6;
	logic [28:0]       ap;

	assign ap = 29'(prod_s5) * 29'(REC60);

	always_ff @(posedge clk) begin
		if (en[5]) begin
			func_s6 <= func_s5;
			vmax_s6 <= vmax_s5;
			vmin_s6 <= vmin_s5;
			sec_s6  <= sec_s5;
			adj_s6  <= ap[REC60_SHIFT +: CHAN_W];
		end
	end

	// stage 7: sector mux, level mode bypass
	chan_t red_s7, green_s7, blue_s7;
	chan_t r_c, g_c, b_c;

	always_comb begin
		case (sec_s6)
			SEC_RED_UP: begin
				r_c = vmax_s6;          g_c = vmin_s6 + adj_s6; b_c = vmin_s6;
			end
			SEC_GRN_DN: begin
				r_c = vmax_s6 - adj_s6; g_c = vmax_s6;          b_c = vmin_s6;
			end
			SEC_GRN_UP: begin
				r_c = vmin_s6;          g_c = vmax_s6;          b_c = vmin_s6 + adj_s6;
			end
			SEC_BLU_DN: begin
				r_c = vmin_s6;          g_c = vmax_s6 - adj_s6; b_c = vmax_s6;
			end
			SEC_BLU_UP: begin
				r_c = vmin_s6 + adj_s6; g_c = vmin_s6;          b_c = vmax_s6;
			end
			default: begin
				r_c = vmax_s6;          g_c = vmin_s6;          b_c = vmax_s6 - adj_s6;
			end
		endcase
		if (func_s6 == FUNC_LEVEL) begin
			r_c = vmax_s6;
			g_c = vmax_s6;
			b_c = vmax_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en[6]) begin
			red_s7   <= r_c;
			green_s7 <= g_c;
			blue_s7  <= b_c;
		end
	end

	assign red   = red_s7;
	assign green = green_s7;
	assign blue  = blue_s7;

endmodule

[src/hrpd_duty.sv]
module hrpd_duty
	import hrpd_pkg::*;
#(
	parameter int PWM_PERIOD = 1000
) (
	input  logic                   clk,
	input  logic [DUTY_STAGES-1:0] en,
	input  chan_t                  x,
	output duty_t                  duty
);

	// x*P/254 = x*(P/254) + x*(P%254)/254; only the low duty bits survive
	localparam int PQ = PWM_PERIOD / FULL_SCALE;
	localparam int PR = PWM_PERIOD % FULL_SCALE;

	duty_t       hi_s8;
	logic [15:0] lo_s8;
	duty_t       duty_s9;
	logic [23:0] hp;
	logic [32:0] qp;

	assign hp = 24'(x) * 24'(PQ);
	assign qp = 33'(lo_s8) * 33'(REC254);

	always_ff @(posedge clk) begin
		if (en[0]) begin
			hi_s8 <= hp[DUTY_W-1:0];
			lo_s8 <= 16'(x) * 16'(PR);
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			duty_s9 <= hi_s8 + DUTY_W'(qp[REC254_SHIFT +: CHAN_W]);
		end
	end

	assign duty = duty_s9;

endmodule
